// ----- sv/tdgs_pkg.sv -----
package tdgs_pkg;

  // Input field widths.
  localparam int CW = 16;
  localparam int ZW = 32;
  localparam int SW = 32;

  // Exact intermediate widths.
  localparam int DXW    = CW + 1;
  localparam int DZW    = ZW + 1;
  localparam int PDETW  = 2 * DXW;
  localparam int DETW   = PDETW + 1;
  localparam int PNUMW  = DZW + DXW;
  localparam int NSHIFT = 4;
  localparam int NUMW   = PNUMW + 1 + NSHIFT;

  // One quotient bit per divider cell: the top bit flags a quotient of 2^32 or more.
  localparam int QBITS = SW + 1;
  localparam int RW    = DETW + QBITS - 1;

  localparam int FRONT_STAGES = 4;
  localparam int LATENCY      = FRONT_STAGES + QBITS + 1;

  localparam logic [SW-1:0] STEP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] STEP_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic [NUMW-1:0] nx_mag;
    logic            nx_neg;
    logic [NUMW-1:0] ny_mag;
    logic            ny_neg;
    logic [DETW-1:0] d_mag;
    logic            d_neg;
    logic            degen;
  } tdgs_prep_t;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [RW-1:0]    dsh;
    logic [QBITS-1:0] quo;
    logic             neg;
    logic             degen;
  } tdgs_lane_t;

endpackage

// ----- sv/triangle_depth_gradient_setup.sv -----
// Channel   Transfer when                 Payload
// input     start high and busy low       vertex0..2 x, y (12.4), vertex0..2 depth (Q16.16)
// result    done high (one cycle)         depth_step_x, depth_step_y, degenerate, saturated
//
// A new triangle can be taken in every cycle outside reset; each one gives
// exactly one result after four setup stages (edge vectors, cross products,
// determinant and numerators, magnitudes), one divider cell per quotient bit
// (33 cells, each lane), and one output register for sign and clamping.
// Reset is synchronous and clears only the valid line; busy stays high during
// reset so no triangle is taken then. The receiver cannot stall, so results
// leave the pipeline as they arrive and nothing ever backs up.
module triangle_depth_gradient_setup import tdgs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] vertex0_x,
  input  logic signed [CW-1:0] vertex0_y,
  input  logic signed [CW-1:0] vertex1_x,
  input  logic signed [CW-1:0] vertex1_y,
  input  logic signed [CW-1:0] vertex2_x,
  input  logic signed [CW-1:0] vertex2_y,
  input  logic signed [ZW-1:0] vertex0_depth,
  input  logic signed [ZW-1:0] vertex1_depth,
  input  logic signed [ZW-1:0] vertex2_depth,
  output logic                 done,
  output logic signed [SW-1:0] depth_step_x,
  output logic signed [SW-1:0] depth_step_y,
  output logic                 degenerate,
  output logic                 saturated
);

  logic       accept;
  logic       prep_valid;
  tdgs_prep_t prep;

  // Lane state between divider cells; entry 0 is the chain input.
  logic       vld    [QBITS+1];
  logic       vld_y  [QBITS+1];
  tdgs_lane_t lane_x [QBITS+1];
  tdgs_lane_t lane_y [QBITS+1];

  logic [SW-1:0] step_x_next, step_y_next;
  logic          sat_x, sat_y;

  // The pipeline never holds anything back, so busy only masks reset.
  assign busy   = rst;
  assign accept = start && !busy;

  tdgs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .vertex0_x     (vertex0_x),
    .vertex0_y     (vertex0_y),
    .vertex1_x     (vertex1_x),
    .vertex1_y     (vertex1_y),
    .vertex2_x     (vertex2_x),
    .vertex2_y     (vertex2_y),
    .vertex0_depth (vertex0_depth),
    .vertex1_depth (vertex1_depth),
    .vertex2_depth (vertex2_depth),
    .prep_valid    (prep_valid),
    .prep          (prep)
  );

  // The divisor enters aligned to quotient bit 32 so that the first cell
  // detects any quotient too large for 32 bits.
  always_comb begin
    vld[0]          = prep_valid;
    vld_y[0]        = prep_valid;
    lane_x[0].rem   = RW'(prep.nx_mag);
    lane_x[0].dsh   = {prep.d_mag, {(QBITS-1){1'b0}}};
    lane_x[0].quo   = '0;
    lane_x[0].neg   = prep.nx_neg ^ prep.d_neg;
    lane_x[0].degen = prep.degen;
    lane_y[0].rem   = RW'(prep.ny_mag);
    lane_y[0].dsh   = {prep.d_mag, {(QBITS-1){1'b0}}};
    lane_y[0].quo   = '0;
    lane_y[0].neg   = prep.ny_neg ^ prep.d_neg;
    lane_y[0].degen = prep.degen;
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    tdgs_div_cell u_cell_x (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .lane_in   (lane_x[i]),
      .out_valid (vld[i+1]),
      .lane_out  (lane_x[i+1])
    );
    tdgs_div_cell u_cell_y (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld_y[i]),
      .lane_in   (lane_y[i]),
      .out_valid (vld_y[i+1]),
      .lane_out  (lane_y[i+1])
    );
  end

  // Applies the quotient sign and clamps to the signed 32-bit range. The top
  // quotient bit means the magnitude reached 2^32 and always saturates.
  function automatic logic [SW:0] finish_step(input tdgs_lane_t l);
    logic [SW-1:0] mag;
    logic          ovf;
    logic [SW-1:0] val;
    mag = l.quo[QBITS-2:0];
    if (l.neg) begin
      ovf = l.quo[QBITS-1] || (mag > STEP_MIN);
      val = ovf ? STEP_MIN : SW'(-mag);
    end else begin
      ovf = l.quo[QBITS-1] || mag[SW-1];
      val = ovf ? STEP_MAX : mag;
    end
    return {ovf, val};
  endfunction

  always_comb begin
    {sat_x, step_x_next} = finish_step(lane_x[QBITS]);
    {sat_y, step_y_next} = finish_step(lane_y[QBITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[QBITS];
    end
  end

  // A zero determinant overrides whatever the divider produced.
  always_ff @(posedge clk) begin
    degenerate   <= lane_x[QBITS].degen;
    depth_step_x <= lane_x[QBITS].degen ? '0 : step_x_next;
    depth_step_y <= lane_x[QBITS].degen ? '0 : step_y_next;
    saturated    <= !lane_x[QBITS].degen && (sat_x || sat_y);
  end

  // Every result traces back to a transfer exactly one pipeline latency ago.
  a_done_has_source : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching input transfer");

  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |->
      (depth_step_x == '0 && depth_step_y == '0 && !saturated))
    else $error("degenerate triangle with nonzero steps or saturation");

  a_sat_clamped : assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (depth_step_x == STEP_MAX || depth_step_x == STEP_MIN ||
       depth_step_y == STEP_MAX || depth_step_y == STEP_MIN))
    else $error("saturation flagged without a clamped step");

  a_lanes_in_step : assert property (@(posedge clk) disable iff (rst)
    vld[QBITS] == vld_y[QBITS])
    else $error("divider lanes out of step");

endmodule

// ----- sv/tdgs_front.sv -----
module tdgs_front import tdgs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] vertex0_x,
  input  logic signed [CW-1:0] vertex0_y,
  input  logic signed [CW-1:0] vertex1_x,
  input  logic signed [CW-1:0] vertex1_y,
  input  logic signed [CW-1:0] vertex2_x,
  input  logic signed [CW-1:0] vertex2_y,
  input  logic signed [ZW-1:0] vertex0_depth,
  input  logic signed [ZW-1:0] vertex1_depth,
  input  logic signed [ZW-1:0] vertex2_depth,
  output logic                 prep_valid,
  output tdgs_prep_t           prep
);

  // Edge vectors relative to the third vertex.
  logic                    dif_valid;
  logic signed [DXW-1:0]   ax, ay, bx, by;
  logic signed [DZW-1:0]   za, zb;

  // Cross products.
  logic                    prod_valid;
  logic signed [PDETW-1:0] p_bxay, p_axby;
  logic signed [PNUMW-1:0] p_zbay, p_zaby, p_zbax, p_zabx;

  // Determinant and scaled numerators.
  logic                    num_valid;
  logic signed [DETW-1:0]  det;
  logic signed [NUMW-1:0]  nx, ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      dif_valid  <= 1'b0;
      prod_valid <= 1'b0;
      num_valid  <= 1'b0;
      prep_valid <= 1'b0;
    end else begin
      dif_valid  <= in_valid;
      prod_valid <= dif_valid;
      num_valid  <= prod_valid;
      prep_valid <= num_valid;
    end
  end

  always_ff @(posedge clk) begin
    ax <= DXW'(vertex0_x) - DXW'(vertex2_x);
    ay <= DXW'(vertex0_y) - DXW'(vertex2_y);
    bx <= DXW'(vertex1_x) - DXW'(vertex2_x);
    by <= DXW'(vertex1_y) - DXW'(vertex2_y);
    za <= DZW'(vertex0_depth) - DZW'(vertex2_depth);
    zb <= DZW'(vertex1_depth) - DZW'(vertex2_depth);

    p_bxay <= bx * ay;
    p_axby <= ax * by;
    p_zbay <= zb * ay;
    p_zaby <= za * by;
    p_zbax <= zb * ax;
    p_zabx <= za * bx;

    det <= DETW'(p_bxay) - DETW'(p_axby);
    nx  <= (NUMW'(p_zbay) - NUMW'(p_zaby)) <<< NSHIFT;
    ny  <= (NUMW'(p_zabx) - NUMW'(p_zbax)) <<< NSHIFT;

    prep.nx_neg <= nx[NUMW-1];
    prep.nx_mag <= nx[NUMW-1] ? NUMW'(-nx) : NUMW'(nx);
    prep.ny_neg <= ny[NUMW-1];
    prep.ny_mag <= ny[NUMW-1] ? NUMW'(-ny) : NUMW'(ny);
    prep.d_neg  <= det[DETW-1];
    prep.d_mag  <= det[DETW-1] ? DETW'(-det) : DETW'(det);
    prep.degen  <= (det == '0);
  end

endmodule

// ----- sv/tdgs_div_cell.sv -----
module tdgs_div_cell import tdgs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  tdgs_lane_t lane_in,
  output logic       out_valid,
  output tdgs_lane_t lane_out
);

  logic [RW:0] diff;
  logic        fits;
  tdgs_lane_t  lane_next;

  // One restoring step: try the shifted divisor, keep the remainder if it fits,
  // and hand the divisor on one place lower.
  always_comb begin
    diff           = {1'b0, lane_in.rem} - {1'b0, lane_in.dsh};
    fits           = !diff[RW];
    lane_next      = lane_in;
    lane_next.rem  = fits ? diff[RW-1:0] : lane_in.rem;
    lane_next.dsh  = lane_in.dsh >> 1;
    lane_next.quo  = {lane_in.quo[QBITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lane_out <= lane_next;
  end

endmodule

// ----- dv/tb_triangle_depth_gradient_setup.sv -----
module tb_triangle_depth_gradient_setup;
  timeunit 1ns;
  timeprecision 1ps;

  import tdgs_pkg::*;

  // One triangle as presented on the input side. The fields hold raw bits.
  // The gradient predictor treats them as signed values.
  typedef struct packed {
    logic [CW-1:0] x0, y0, x1, y1, x2, y2;
    logic [ZW-1:0] z0, z1, z2;
  } triangle_t;

  // One result transfer: both depth steps and the two flags.
  typedef struct packed {
    logic [SW-1:0] step_x;
    logic [SW-1:0] step_y;
    logic          degenerate;
    logic          saturated;
  } gradient_t;

  // These are the families of random triangles. Full-range triangles toggle
  // every input bit. Screen-sized triangles give ordinary in-range gradients.
  // Collinear ones have zero area. Slivers have a tiny area, so their steps
  // often clip.
  typedef enum int {
    SHAPE_FULL,
    SHAPE_SCREEN,
    SHAPE_COLLINEAR,
    SHAPE_SLIVER
  } shape_e;

  localparam int ZMAX = 2147483647;
  localparam int ZMIN = -2147483647 - 1;

  // The scoreboard computes the expected gradients of each accepted triangle
  // in exact 64-bit arithmetic. It compares each result transfer with the
  // oldest gradient still owed.
  class gradient_scoreboard;
    gradient_t owed_gradients[$];
    int        mismatches;
    int        results_seen;

    function automatic logic [SW-1:0] clamp_step(input longint q, inout bit clipped);
      if (q > longint'($signed(STEP_MAX))) begin
        clipped = 1'b1;
        return STEP_MAX;
      end
      if (q < longint'($signed(STEP_MIN))) begin
        clipped = 1'b1;
        return STEP_MIN;
      end
      return q[SW-1:0];
    endfunction

    function automatic gradient_t gradient_of(triangle_t t);
      longint    ax, ay, bx, by, za, zb, area;
      bit        clipped;
      gradient_t g;
      ax = longint'($signed(t.x0)) - longint'($signed(t.x2));
      ay = longint'($signed(t.y0)) - longint'($signed(t.y2));
      bx = longint'($signed(t.x1)) - longint'($signed(t.x2));
      by = longint'($signed(t.y1)) - longint'($signed(t.y2));
      za = longint'($signed(t.z0)) - longint'($signed(t.z2));
      zb = longint'($signed(t.z1)) - longint'($signed(t.z2));
      area = bx * ay - ax * by;
      g = '0;
      clipped = 1'b0;
      if (area == 0) begin
        g.degenerate = 1'b1;
      end else begin
        // SV division of signed longints rounds toward zero, as required.
        g.step_x    = clamp_step((16 * (zb * ay - za * by)) / area, clipped);
        g.step_y    = clamp_step((-16 * (zb * ax - za * bx)) / area, clipped);
        g.saturated = clipped;
      end
      return g;
    endfunction

    function void note_triangle(triangle_t t);
      owed_gradients.push_back(gradient_of(t));
    endfunction

    function int pending();
      return owed_gradients.size();
    endfunction

    task report(string what);
      $display("%0t ns: result %0d: %s", $time, results_seen, what);
      mismatches++;
    endtask

    task check_result(gradient_t got);
      gradient_t want;
      if (owed_gradients.size() == 0) begin
        report("result with no triangle outstanding");
      end else begin
        want = owed_gradients.pop_front();
        if (got.step_x !== want.step_x)
          report($sformatf("depth_step_x got %08h want %08h", got.step_x, want.step_x));
        if (got.step_y !== want.step_y)
          report($sformatf("depth_step_y got %08h want %08h", got.step_y, want.step_y));
        if (got.degenerate !== want.degenerate)
          report($sformatf("degenerate got %b want %b", got.degenerate, want.degenerate));
        if (got.saturated !== want.saturated)
          report($sformatf("saturated got %b want %b", got.saturated, want.saturated));
      end
      results_seen++;
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [CW-1:0] vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y;
  logic signed [ZW-1:0] vertex0_depth, vertex1_depth, vertex2_depth;
  logic                 done;
  logic signed [SW-1:0] depth_step_x, depth_step_y;
  logic                 degenerate, saturated;

  gradient_scoreboard sb = new;

  // This is the percentage of cycles in which the sender holds start low
  // before it offers a triangle.
  int idle_pct;

  triangle_depth_gradient_setup uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .vertex0_x     (vertex0_x),
    .vertex0_y     (vertex0_y),
    .vertex1_x     (vertex1_x),
    .vertex1_y     (vertex1_y),
    .vertex2_x     (vertex2_x),
    .vertex2_y     (vertex2_y),
    .vertex0_depth (vertex0_depth),
    .vertex1_depth (vertex1_depth),
    .vertex2_depth (vertex2_depth),
    .done          (done),
    .depth_step_x  (depth_step_x),
    .depth_step_y  (depth_step_y),
    .degenerate    (degenerate),
    .saturated     (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are observed at the rising edge, in the same place. An
  // input transfer records the gradients it owes. A done cycle consumes the
  // oldest one. As the pipeline is deep, the two never touch the same triangle
  // at one edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.note_triangle('{vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
                           vertex0_depth, vertex1_depth, vertex2_depth});
      if (done)
        sb.check_result('{depth_step_x, depth_step_y, degenerate, saturated});
    end
  end

  // Coordinates and depths are given as plain ints and cut to port width here,
  // so a caller can write signed extremes directly.
  function automatic triangle_t make_tri(int x0, int y0, int x1, int y1, int x2, int y2,
                                         int z0, int z1, int z2);
    triangle_t t;
    t.x0 = x0[CW-1:0];
    t.y0 = y0[CW-1:0];
    t.x1 = x1[CW-1:0];
    t.y1 = y1[CW-1:0];
    t.x2 = x2[CW-1:0];
    t.y2 = y2[CW-1:0];
    t.z0 = z0;
    t.z1 = z1;
    t.z2 = z2;
    return t;
  endfunction

  function automatic int signed_range(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic triangle_t random_triangle();
    shape_e    shape;
    int        pick, bx0, by0, dx, dy, k1, k2;
    triangle_t t;
    pick = $urandom_range(99);
    if (pick < 30)      shape = SHAPE_FULL;
    else if (pick < 70) shape = SHAPE_SCREEN;
    else if (pick < 85) shape = SHAPE_COLLINEAR;
    else                shape = SHAPE_SLIVER;
    // The depths start fully random. Some screen triangles then get a gentle
    // depth ramp, so that the result bits away from the clamp values are
    // exercised as well.
    t.z0 = $urandom;
    t.z1 = $urandom;
    t.z2 = $urandom;
    case (shape)
      SHAPE_FULL: begin
        t.x0 = CW'($urandom); t.y0 = CW'($urandom);
        t.x1 = CW'($urandom); t.y1 = CW'($urandom);
        t.x2 = CW'($urandom); t.y2 = CW'($urandom);
      end
      SHAPE_SCREEN: begin
        t = make_tri(signed_range(8000), signed_range(8000), signed_range(8000),
                     signed_range(8000), signed_range(8000), signed_range(8000),
                     t.z0, t.z1, t.z2);
        if ($urandom_range(1)) begin
          t.z1 = t.z0 + signed_range(1 << 20);
          t.z2 = t.z0 + signed_range(1 << 20);
        end
      end
      SHAPE_COLLINEAR: begin
        // All three points are whole multiples of one direction from a base
        // point, so the area is exactly zero. Sometimes two points coincide.
        bx0 = signed_range(20000);
        by0 = signed_range(20000);
        dx  = signed_range(200);
        dy  = signed_range(200);
        k1  = signed_range(10);
        k2  = $urandom_range(3) == 0 ? 0 : signed_range(10);
        t = make_tri(bx0, by0, bx0 + k1 * dx, by0 + k1 * dy, bx0 + k2 * dx, by0 + k2 * dy,
                     t.z0, t.z1, t.z2);
      end
      default: begin
        bx0 = signed_range(30000);
        by0 = signed_range(30000);
        t = make_tri(bx0, by0, bx0 + signed_range(3), by0 + signed_range(3),
                     bx0 + signed_range(3), by0 + signed_range(3), t.z0, t.z1, t.z2);
      end
    endcase
    return t;
  endfunction

  // The sender changes its inputs only at the falling edge. It may idle first,
  // with start low. Then it holds the triangle until a rising edge sees busy
  // low. Start stays high between back-to-back triangles, so each time step
  // gets at most one assignment to it.
  task automatic offer_triangle(triangle_t t);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    vertex0_x     <= t.x0;
    vertex0_y     <= t.y0;
    vertex1_x     <= t.x1;
    vertex1_y     <= t.y1;
    vertex2_x     <= t.x2;
    vertex2_y     <= t.y2;
    vertex0_depth <= t.z0;
    vertex1_depth <= t.z1;
    vertex2_depth <= t.z2;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    triangle_t directed[$];

    rst           = 1'b1;
    start         = 1'b0;
    vertex0_x     = '0;
    vertex0_y     = '0;
    vertex1_x     = '0;
    vertex1_y     = '0;
    vertex2_x     = '0;
    vertex2_y     = '0;
    vertex0_depth = '0;
    vertex1_depth = '0;
    vertex2_depth = '0;
    idle_pct      = 26;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The directed triangles cover the following cases:
    // - an all-zero triangle;
    // - one-pixel right triangles in both windings;
    // - screen corners with extreme depths;
    // - flat depth planes;
    // - coincident and collinear points;
    // - the smallest possible area with opposite extreme depths, which clips
    //   high and low;
    // - a step that lands exactly on the negative limit without clipping.
    directed.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_tri(0, 0, 16, 0, 0, 16, 0, 65536, 0));
    directed.push_back(make_tri(0, 0, 0, 16, 16, 0, 0, 65536, 131072));
    directed.push_back(make_tri(-32768, -32768, 32767, -32768, -32768, 32767, ZMAX, ZMIN, 0));
    directed.push_back(make_tri(32767, 32767, -32768, 32767, 32767, -32768, ZMIN, ZMAX, ZMAX));
    directed.push_back(make_tri(-32768, 32767, 32767, -32768, -32768, -32768, ZMAX, ZMAX, ZMAX));
    directed.push_back(make_tri(-32768, 32767, 32767, -32768, -32768, -32768, ZMIN, ZMIN, ZMIN));
    directed.push_back(make_tri(100, -200, 100, -200, 100, -200, ZMAX, ZMIN, 5));
    directed.push_back(make_tri(-32768, -32768, 0, 0, 32767, 32767, ZMAX, ZMIN, -1));
    directed.push_back(make_tri(-30000, 5, 100, 5, 30000, 5, 1, ZMAX, ZMIN));
    directed.push_back(make_tri(0, 0, 1, 0, 0, 1, ZMAX, ZMIN, 0));
    directed.push_back(make_tri(0, 0, 1, 0, 0, 1, ZMIN, ZMAX, 0));
    directed.push_back(make_tri(0, 0, 0, 1, 1, 0, ZMAX, ZMIN, 0));
    directed.push_back(make_tri(0, 0, 16, 0, 0, 16, ZMAX, ZMIN, 0));
    directed.push_back(make_tri(0, 0, 16, 0, 0, 16, 0, ZMIN, 0));
    directed.push_back(make_tri(-1, -1, 32767, -32768, -32768, 32767, -1, 1, ZMAX));
    directed.push_back(make_tri(16'h5555, 16'h2aaa, 16'h2aaa, 16'h5555, 0, 0,
                                32'h5555_5555, 32'h2aaa_aaaa, 0));
    directed.push_back(make_tri(48, 32, -64, 80, 16, -96, 1 << 16, 3 << 16, -(5 << 16)));

    foreach (directed[i])
      offer_triangle(directed[i]);

    for (int n = 0; n < 1450; n++) begin
      // A long run of back-to-back triangles keeps the pipeline full. Later in the
      // run, the sender drops start and drains the pipeline completely before it
      // goes on.
      idle_pct = (n >= 500 && n < 800) ? 0 : 26;
      if (n == 1000) begin
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      offer_triangle(random_triangle());
    end
    @(negedge clk);
    start <= 1'b0;

    // Wait for every owed gradient, then watch for stray results for longer than
    // the pipeline takes to drain.
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (sb.mismatches == 0)
      $display("tb_triangle_depth_gradient_setup: done, clean");
    else
      $display("tb_triangle_depth_gradient_setup: done, errors");
    $finish;
  end

  // This time limit lies far above the length of a correct run.
  initial begin
    #5_000_000;
    $display("tb_triangle_depth_gradient_setup: done, errors");
    $finish;
  end

endmodule
